### rtl/rcb_pkg.sv
// shared constants and types for the rod-cutting best-value block
// no dependencies
package rcb_pkg;

    localparam int MAX_LEN = 64;
    localparam int PRICE_W = 16;
    localparam int VALUE_W = 22;
    localparam int LEN_W   = 7;
    localparam int PIECE_W = 6;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // sequencer to scan unit control
    typedef struct packed {
        logic start;   // load the uncut price as the running best
        logic issue;   // a table read pair was issued this cycle
    } t_scan_ctl;

endpackage

### rtl/rcb_if.sv
// handshake channels of the rod-cutting block: price beats in, result beats out
// depends on rcb_pkg for field widths
interface rcb_in_if;
    logic                        valid;
    logic                        ready;
    logic [rcb_pkg::PRICE_W-1:0] price;
    logic                        restart;

    modport source (output valid, output price, output restart, input ready);
    modport sink   (input valid, input price, input restart, output ready);
endinterface

interface rcb_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcb_pkg::LEN_W-1:0]   rod_length;
    logic [rcb_pkg::VALUE_W-1:0] best_value;
    logic [rcb_pkg::PIECE_W-1:0] cut_piece;
    logic [rcb_pkg::PIECE_W-1:0] rest_piece;
    logic                        full_res;

    modport source (output valid, output rod_length, output best_value, output cut_piece,
                    output rest_piece, output full_res, input ready);
    modport sink   (input valid, input rod_length, input best_value, input cut_piece,
                    input rest_piece, input full_res, output ready);
endinterface

### rtl/rcb_table.sv
// best-value table: one write port, two registered read ports
// depends on rcb_pkg for the value width
module rcb_table #(
    parameter int DEPTH = rcb_pkg::MAX_LEN,
    parameter int AW    = $clog2(rcb_pkg::MAX_LEN)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_wa,
    input  logic [rcb_pkg::VALUE_W-1:0] i_wd,
    input  logic [AW-1:0]               i_ra,
    input  logic [AW-1:0]               i_rb,
    output logic [rcb_pkg::VALUE_W-1:0] o_rd_a,
    output logic [rcb_pkg::VALUE_W-1:0] o_rd_b
);

    logic [rcb_pkg::VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd_a <= r_mem[i_ra];
        o_rd_b <= r_mem[i_rb];
    end

endmodule

### rtl/rcb_scan.sv
// shared scan unit: saturating add of a read pair, then max/split compare
// depends on rcb_pkg for widths and the control struct
module rcb_scan #(
    parameter int CW = $clog2(rcb_pkg::MAX_LEN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcb_pkg::t_scan_ctl          i_ctl,
    input  logic [rcb_pkg::PRICE_W-1:0] i_price,
    input  logic [CW-1:0]               i_k,
    input  logic [rcb_pkg::VALUE_W-1:0] i_rd_a,
    input  logic [rcb_pkg::VALUE_W-1:0] i_rd_b,
    output logic                        o_busy,
    output logic [rcb_pkg::VALUE_W-1:0] o_best,
    output logic [CW-1:0]               o_cut
);

    logic                        r_v1, r_v2;
    logic [CW-1:0]               r_k1, r_k2;
    logic [rcb_pkg::VALUE_W-1:0] r_sum;
    logic [rcb_pkg::VALUE_W-1:0] r_best;
    logic [CW-1:0]               r_cut;
    logic [rcb_pkg::VALUE_W:0]   sum_raw;
    logic [rcb_pkg::VALUE_W-1:0] n_sum;

    assign sum_raw = {1'b0, i_rd_a} + {1'b0, i_rd_b};
    assign n_sum   = sum_raw[rcb_pkg::VALUE_W] ? rcb_pkg::VALUE_MAX
                                               : sum_raw[rcb_pkg::VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1  <= i_k;
        r_k2  <= r_k1;
        r_sum <= n_sum;
        if (i_ctl.start) begin
            r_best <= rcb_pkg::VALUE_W'(i_price);
            r_cut  <= '0;
        end else if (r_v2 && (r_sum >= r_best)) begin
            // ties move the split to the larger first piece
            r_best <= r_sum;
            r_cut  <= r_k2;
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_best = r_best;
    assign o_cut  = r_cut;

endmodule

### rtl/rod_cutting_best_value.sv
// Rod-cutting best value, built one length per input beat.
// Input channel i_in carries price and restart; output channel o_out carries
// rod_length, best_value, cut_piece, rest_piece and full_res, one result beat
// per input beat, in order.
// A beat for length n > 1 scans the n-1 splits, one table read pair per cycle
// through one shared saturating adder and comparator, then drains a two-stage
// pipe: the result is loaded once the pipe is empty and the output register
// is free, and the input is ready again from that edge on. Length one and
// refused beats skip the scan and load their result under the same condition.
// The single scan unit works on one beat at a time.
// The input is ready only while no beat is in work. A finished result sits in
// the output register; the next beat is taken while it waits, and its own
// result is held in the scan unit until the output register frees.
// Reset clears the stored length count, so the first beat is length one; the
// table itself is not cleared, since only written entries are ever read.
// Beats past MAX_LEN lengths without restart are refused with full_res set.
// Depends on rcb_pkg, rcb_if, rcb_table and rcb_scan.
module rod_cutting_best_value #(
    parameter int MAX_LEN = rcb_pkg::MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcb_in_if.sink      i_in,
    rcb_out_if.source   o_out
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int LW = rcb_pkg::LEN_W + CW;
    localparam int PW = rcb_pkg::PIECE_W + CW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_n;
    logic [CW-1:0]               r_k;
    logic                        r_full;

    logic                        in_acc;
    logic [CW-1:0]               eff_count;
    logic                        is_full;
    logic [CW-1:0]               n_len;
    logic                        finish;
    logic                        tbl_we;

    rcb_pkg::t_scan_ctl          scan_ctl;
    logic                        scan_busy;
    logic [rcb_pkg::VALUE_W-1:0] scan_best;
    logic [CW-1:0]               scan_cut;
    logic [rcb_pkg::VALUE_W-1:0] rd_a, rd_b;
    logic [CW-1:0]               addr_a, addr_b;
    logic [CW-1:0]               rest_len;
    logic [LW-1:0]               n_ext;
    logic [PW-1:0]               cut_ext, rest_ext;

    function automatic logic [AW-1:0] addr_len_m1(input logic [CW-1:0] len);
        logic [CW-1:0] m1;
        m1 = len - CW'(1);
        return m1[AW-1:0];
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;
    assign eff_count  = i_in.restart ? '0 : r_count;
    assign is_full    = (eff_count == CW'(MAX_LEN));
    assign n_len      = eff_count + CW'(1);

    assign finish = (r_state == S_DRAIN) && !scan_busy && (!o_out.valid || o_out.ready);
    assign tbl_we = finish && !r_full;

    // pair k-1 and n-k-1 for the split at first piece k
    assign addr_a = r_k - CW'(1);
    assign addr_b = r_n - r_k - CW'(1);

    assign scan_ctl.start = in_acc;
    assign scan_ctl.issue = (r_state == S_SCAN);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (is_full || n_len == CW'(1)) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == r_n - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (tbl_we) begin
                r_count <= r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_n    <= n_len;
            r_k    <= CW'(1);
            r_full <= is_full;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + CW'(1);
        end
    end

    rcb_table #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_wa   (addr_len_m1(r_n)),
        .i_wd   (scan_best),
        .i_ra   (addr_a[AW-1:0]),
        .i_rb   (addr_b[AW-1:0]),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    rcb_scan #(
        .CW (CW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_price (i_in.price),
        .i_k     (r_k),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_busy  (scan_busy),
        .o_best  (scan_best),
        .o_cut   (scan_cut)
    );

    assign rest_len = (scan_cut != '0) ? (r_n - scan_cut) : '0;
    assign n_ext    = LW'(r_n);
    assign cut_ext  = PW'(scan_cut);
    assign rest_ext = PW'(rest_len);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (finish) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_full) begin
                o_out.rod_length <= '0;
                o_out.best_value <= '0;
                o_out.cut_piece  <= '0;
                o_out.rest_piece <= '0;
                o_out.full_res   <= 1'b1;
            end else begin
                o_out.rod_length <= n_ext[rcb_pkg::LEN_W-1:0];
                o_out.best_value <= scan_best;
                o_out.cut_piece  <= cut_ext[rcb_pkg::PIECE_W-1:0];
                o_out.rest_piece <= rest_ext[rcb_pkg::PIECE_W-1:0];
                o_out.full_res   <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("stored length count beyond table depth");

    a_ready_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !scan_busy)
        else $error("input ready while scan pipe holds a read pair");

    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_state == S_DRAIN) && !scan_busy && (r_n != '0))
        else $error("table write before the scan has drained");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out.valid && (r_state == S_IDLE))
        else $error("finished beat not presented at the output");

endmodule

### bench/rod_cutting_best_value_checker.sv
// result checker for the rod-cutting best-value block: watches both channels,
// predicts every result beat and compares it with what the block returns
// depends on rcb_pkg and the channel interfaces in rcb_if
module rod_cutting_best_value_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rcb_in_if    i_in,
    rcb_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rcb_pkg::LEN_W-1:0]   rod_length;
        logic [rcb_pkg::VALUE_W-1:0] best_value;
        logic [rcb_pkg::PIECE_W-1:0] cut_piece;
        logic [rcb_pkg::PIECE_W-1:0] rest_piece;
        logic                        full_res;
    } t_rod_result;

    logic [rcb_pkg::VALUE_W-1:0] best_tbl [rcb_pkg::MAX_LEN];
    int                          stored_len;
    t_rod_result                 expected_q [$];
    int                          mismatches;

    function automatic logic [rcb_pkg::VALUE_W-1:0] sat_sum(
        input logic [rcb_pkg::VALUE_W-1:0] a,
        input logic [rcb_pkg::VALUE_W-1:0] b
    );
        logic [rcb_pkg::VALUE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, rcb_pkg::VALUE_MAX}) ? rcb_pkg::VALUE_MAX
                                                 : s[rcb_pkg::VALUE_W-1:0];
    endfunction

    // best value and split for the next length, table updated as a side effect
    function automatic t_rod_result cut_rod_predict(
        input logic [rcb_pkg::PRICE_W-1:0] price,
        input logic                        restart
    );
        t_rod_result                 r;
        int                          n;
        int                          cut;
        logic [rcb_pkg::VALUE_W-1:0] best;
        logic [rcb_pkg::VALUE_W-1:0] s;
        r = '0;
        if (restart) stored_len = 0;
        if (stored_len >= rcb_pkg::MAX_LEN) begin
            r.full_res = 1'b1;
            return r;
        end
        n    = stored_len + 1;
        best = rcb_pkg::VALUE_W'(price);
        for (int k = 1; k < n; k++) begin
            s = sat_sum(best_tbl[k-1], best_tbl[n-k-1]);
            if (s > best) best = s;
        end
        // largest first piece that reaches the best
        cut = 0;
        for (int k = 1; k < n; k++) begin
            s = sat_sum(best_tbl[k-1], best_tbl[n-k-1]);
            if (s == best) cut = k;
        end
        best_tbl[n-1] = best;
        stored_len    = n;
        r.rod_length  = rcb_pkg::LEN_W'(n);
        r.best_value  = best;
        r.cut_piece   = rcb_pkg::PIECE_W'(cut);
        r.rest_piece  = (cut != 0) ? rcb_pkg::PIECE_W'(n - cut) : '0;
        return r;
    endfunction

    initial begin
        stored_len = 0;
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        t_rod_result got;
        t_rod_result want;
        if (!i_rst_n) begin
            stored_len = 0;
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = {i_res.rod_length, i_res.best_value, i_res.cut_piece,
                       i_res.rest_piece, i_res.full_res};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result beat: len %0d best %0d",
                                  " cut %0d rest %0d full %0d"},
                                 got.rod_length, got.best_value, got.cut_piece,
                                 got.rest_piece, got.full_res);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: len %0d/%0d best %0d/%0d cut %0d/%0d",
                                      " rest %0d/%0d full %0d/%0d (expected/actual)"},
                                     want.rod_length, got.rod_length,
                                     want.best_value, got.best_value,
                                     want.cut_piece, got.cut_piece,
                                     want.rest_piece, got.rest_piece,
                                     want.full_res, got.full_res);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(cut_rod_predict(i_in.price, i_in.restart));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_q.size();
    end

endmodule

### bench/rod_cutting_best_value_tb.sv
// top of the rod-cutting best-value testbench: clock, reset, price stimulus,
// result back-pressure and the verdict
// depends on rcb_pkg, rcb_if, the block and rod_cutting_best_value_checker
module rod_cutting_best_value_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * rcb_pkg::MAX_LEN + 20;

    typedef enum {
        PR_RANDOM,
        PR_SMALL,
        PR_LINEAR,
        PR_TOP,
        PR_ZERO,
        PR_BUMPY
    } t_price_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    int   sent;
    bit   no_idle;

    rcb_in_if  in_ch ();
    rcb_out_if out_ch ();

    rod_cutting_best_value uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rod_cutting_best_value_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one price beat, with a random gap in front unless idling is off
    task automatic send_price(input logic [rcb_pkg::PRICE_W-1:0] price, input logic restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.price   <= price;
        in_ch.restart <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [rcb_pkg::PRICE_W-1:0] pick_price(input t_price_mode mode,
                                                               input int n,
                                                               input int step);
        int v;
        case (mode)
            PR_SMALL:  v = $urandom_range(0, 15);
            PR_LINEAR: v = n * step;
            PR_TOP:    v = 65535 - $urandom_range(0, 3);
            PR_ZERO:   v = 0;
            PR_BUMPY:  v = n * n * 15;
            default:   v = $urandom_range(0, 65535);
        endcase
        return (v > 65535) ? 16'hffff : rcb_pkg::PRICE_W'(v);
    endfunction

    // result side: random stall before each result beat
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        logic [rcb_pkg::PRICE_W-1:0] classic [8];
        t_price_mode                 mode;
        int                          seq_len;
        int                          step;
        int                          seq_idx;
        logic                        rs;
        classic = '{16'd1, 16'd5, 16'd8, 16'd9, 16'd10, 16'd17, 16'd17, 16'd20};
        sent          = 0;
        no_idle       = 1'b0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.price   <= '0;
        in_ch.restart <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first beat after reset is length one without restart
        send_price(16'd0, 1'b0);
        send_price(16'hffff, 1'b0);
        send_price(16'd1, 1'b0);
        // all-max prices
        send_price(16'hffff, 1'b1);
        send_price(16'hffff, 1'b0);
        send_price(16'hffff, 1'b0);
        send_price(16'd0, 1'b0);
        // linear prices tie every split
        for (int n = 1; n <= 5; n++) send_price(rcb_pkg::PRICE_W'(n), n == 1);
        // textbook price list, then restart in the middle of a table
        for (int n = 0; n < 8; n++) send_price(classic[n], n == 0);
        send_price(16'd3, 1'b1);
        send_price(16'd100, 1'b0);
        wait_all_results();

        seq_idx = 0;
        while (sent < ITEM_TARGET) begin
            mode    = t_price_mode'($urandom_range(0, 5));
            step    = $urandom_range(1, 1000);
            no_idle = ($urandom_range(0, 3) == 0);
            // every few tables run past the end to reach the full flag
            if (seq_idx % 6 == 0)
                seq_len = $urandom_range(rcb_pkg::MAX_LEN + 1, rcb_pkg::MAX_LEN + 5);
            else
                seq_len = $urandom_range(1, 20);
            for (int j = 0; j < seq_len; j++) begin
                rs = (j == 0) || ($urandom_range(0, 29) == 0);
                send_price(pick_price(mode, j + 1, step), rs);
            end
            if (seq_idx == 4) wait_all_results();
            seq_idx++;
        end
        no_idle = 1'b0;

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/rcb_pkg.sv
rtl/rcb_if.sv
rtl/rcb_table.sv
rtl/rcb_scan.sv
rtl/rod_cutting_best_value.sv
bench/rod_cutting_best_value_checker.sv
bench/rod_cutting_best_value_tb.sv
